// ===== rtl/core/ted_pkg.sv =====
// Shared types, constants and the character acceptance function for the
// text encoding detector. No dependencies.
package ted_pkg;

	// Default number of examined bytes per buffer
	localparam int MAX_BYTES_DEF = 2048;

	// Configuration register
	localparam int          MIN_W         = 4;
	localparam logic [3:0]  MIN_ASCII_RST = 4'd5;

	// UTF-16 unit counters saturate at their top value
	localparam int          COUNT_W   = 4;
	localparam logic [3:0]  COUNT_MAX = 4'd15;

	// Code point width and special values
	localparam int           CP_W      = 21;
	localparam logic [20:0]  CP_BOM    = 21'h00FEFF;
	localparam logic [20:0]  CP_MIN3   = 21'h000800;
	localparam logic [20:0]  CP_MIN4   = 21'h010000;
	localparam logic [20:0]  CP_MAX    = 21'h10FFFF;
	localparam logic [9:0]   CP_SURR   = 10'h01B;
	localparam logic [20:0]  ASCII_LIM = 21'd127;

	// UTF-8 sequence lengths
	localparam logic [2:0] SEQ_NONE = 3'd0;
	localparam logic [2:0] SEQ_1    = 3'd1;
	localparam logic [2:0] SEQ_2    = 3'd2;
	localparam logic [2:0] SEQ_3    = 3'd3;
	localparam logic [2:0] SEQ_4    = 3'd4;

	// Result codes
	localparam logic [2:0] ENC_UNKNOWN = 3'd0;
	localparam logic [2:0] ENC_UTF16LE = 3'd1;
	localparam logic [2:0] ENC_UTF16BE = 3'd2;
	localparam logic [2:0] ENC_ASCII   = 3'd3;
	localparam logic [2:0] ENC_UTF8    = 3'd4;

	// Control into one UTF-16 lane
	typedef struct packed {
		logic take;
		logic clear;
		logic at_zero;
	} lane_ctrl_t;

	// Next status of one UTF-16 lane
	typedef struct packed {
		logic               failed;
		logic [COUNT_W-1:0] count;
	} lane_status_t;

	// Printable or accepted control character
	function automatic logic char_ok(input logic [20:0] c);
		logic ok;
		if (c < 21'd32) begin
			ok = (c >= 21'd7 && c <= 21'd13) || c == 21'h1B;
		end else if (c <= 21'h02FA1F) begin
			ok = 1'b1;
		end else if (c >= 21'h0E0000 && c <= 21'h0E01EF) begin
			ok = 1'b1;
		end else begin
			ok = c >= 21'h0F0000 && c <= CP_MAX;
		end
		return ok;
	endfunction

endpackage

// ===== rtl/core/ted_utf16_lane.sv =====
// One UTF-16 byte-order lane: checks each 16-bit unit and counts low units.
// Depends on ted_pkg.
module ted_utf16_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ted_pkg::lane_ctrl_t  ctrl,
	input  logic [15:0]          unit,
	output ted_pkg::lane_status_t status_nxt
);

	logic                        failed_q;
	logic [ted_pkg::COUNT_W-1:0] count_q;
	logic [20:0]                 unit_ext;
	logic                        unit_bad;

	assign unit_ext = {5'd0, unit};
	assign unit_bad = !ted_pkg::char_ok(unit_ext) ||
		(unit_ext == ted_pkg::CP_BOM && !ctrl.at_zero);

	// Next status, also used by the verdict of a closing transfer
	always_comb begin
		status_nxt.failed = failed_q;
		status_nxt.count  = count_q;
		if (ctrl.take) begin
			status_nxt.failed = failed_q | unit_bad;
			if (unit_ext < ted_pkg::ASCII_LIM && count_q != ted_pkg::COUNT_MAX) begin
				status_nxt.count = count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			failed_q <= 1'b0;
			count_q  <= '0;
		end else if (ctrl.clear) begin
			failed_q <= 1'b0;
			count_q  <= '0;
		end else begin
			failed_q <= status_nxt.failed;
			count_q  <= status_nxt.count;
		end
	end

endmodule

// ===== rtl/core/text_encoding_detector.sv =====
// Top level of the text encoding detector: input register, UTF-8 decoder,
// two UTF-16 lanes and the result register. Depends on ted_pkg, ted_utf16_lane.
//
// channel  | handshake             | payload
// ---------+-----------------------+------------------------------
// byte     | byte_valid/byte_stall | data_byte, last, no_byte
// result   | result_valid/stall    | encoding
// cfg      | cfg_valid/cfg_ready   | cfg_data (utf16_min_ascii)
//
// One item per cycle unless byte_stall is high: a transfer lands in the input
// register, and from there the item updates the decoder state and, for a
// closing item, loads the result register, which then holds the valid result.
// Reset clears all control state; utf16_min_ascii returns to 5.
// A stall on result only holds the input register when it holds a closing
// item and the result register is still full; other items keep flowing.
module text_encoding_detector #(
	parameter int MAX_BYTES = ted_pkg::MAX_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        last,
	input  logic        no_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  encoding,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data
);

	localparam int CNT_W = $clog2(MAX_BYTES + 1);

	// Input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       none_s1;

	// Configuration
	logic [ted_pkg::MIN_W-1:0] min_ascii_q;

	// Buffer state
	logic [CNT_W-1:0]          count_q;
	logic [CNT_W-1:0]          count_nxt;
	logic [7:0]                held_q;
	logic [1:0]                rem_q, rem_nxt;
	logic [2:0]                len_q, len_nxt;
	logic [ted_pkg::CP_W-1:0]  cp_q, cp_nxt;
	logic                      start_q, start_nxt;
	logic                      bad_q, bad_nxt;
	logic                      fail_q, fail_nxt;
	logic                      ascii_q, ascii_nxt;
	logic                      fin;

	// Handshake
	logic adv;
	logic take;
	logic clear;
	logic out_valid_q;
	logic [2:0] enc_q;
	logic [2:0] verdict;

	ted_pkg::lane_ctrl_t   lane_ctrl;
	ted_pkg::lane_status_t le_st, be_st;
	logic                  even, le_ok, be_ok;

	assign cfg_ready    = 1'b1;
	assign result_valid = out_valid_q;
	assign encoding     = enc_q;

	// The stage moves unless a closing item waits for the result register
	assign adv        = valid_s1 && (!last_s1 || !out_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !adv;
	assign take       = adv && !none_s1 && (count_q < CNT_W'(MAX_BYTES));
	assign clear      = adv && last_s1;
	assign count_nxt  = take ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			last_s1 <= last;
			none_s1 <= no_byte;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_ascii_q <= ted_pkg::MIN_ASCII_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_ascii_q <= cfg_data;
		end
	end

	// UTF-16 lanes: even bytes are held, odd bytes complete a unit
	assign lane_ctrl.take    = take && count_q[0];
	assign lane_ctrl.clear   = clear;
	assign lane_ctrl.at_zero = (count_q == CNT_W'(1));

	ted_utf16_lane u_le (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.unit       ({byte_s1, held_q}),
		.status_nxt (le_st)
	);

	ted_utf16_lane u_be (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (lane_ctrl),
		.unit       ({held_q, byte_s1}),
		.status_nxt (be_st)
	);

	// UTF-8 decode step
	always_comb begin
		rem_nxt   = rem_q;
		len_nxt   = len_q;
		cp_nxt    = cp_q;
		start_nxt = start_q;
		bad_nxt   = bad_q;
		fail_nxt  = fail_q;
		ascii_nxt = ascii_q;
		fin       = 1'b0;
		if (take && !fail_q) begin
			if (rem_q == 2'd0) begin
				start_nxt = (count_q == '0);
				bad_nxt   = 1'b0;
				if (!byte_s1[7]) begin
					len_nxt = ted_pkg::SEQ_1;
					cp_nxt  = {13'd0, byte_s1};
					fin     = 1'b1;
				end else begin
					ascii_nxt = 1'b0;
					if (byte_s1[7:5] == 3'b110) begin
						len_nxt = ted_pkg::SEQ_2;
						cp_nxt  = {16'd0, byte_s1[4:0]};
						rem_nxt = 2'd1;
					end else if (byte_s1[7:4] == 4'b1110) begin
						len_nxt = ted_pkg::SEQ_3;
						cp_nxt  = {17'd0, byte_s1[3:0]};
						rem_nxt = 2'd2;
					end else if (byte_s1[7:3] == 5'b11110) begin
						len_nxt = ted_pkg::SEQ_4;
						cp_nxt  = {18'd0, byte_s1[2:0]};
						rem_nxt = 2'd3;
					end else begin
						fail_nxt = 1'b1;
						len_nxt  = ted_pkg::SEQ_NONE;
					end
				end
			end else begin
				bad_nxt = bad_q | (byte_s1[7:6] != 2'b10);
				cp_nxt  = {cp_q[14:0], byte_s1[5:0]};
				rem_nxt = rem_q - 2'd1;
				fin     = (rem_q == 2'd1);
			end
			// Checks on a completed sequence
			if (fin) begin
				if (bad_nxt || !ted_pkg::char_ok(cp_nxt) ||
					(cp_nxt == ted_pkg::CP_BOM && !start_nxt)) begin
					fail_nxt = 1'b1;
				end else if (len_nxt == ted_pkg::SEQ_3 && (cp_nxt < ted_pkg::CP_MIN3 ||
					cp_nxt[20:11] == ted_pkg::CP_SURR)) begin
					fail_nxt = 1'b1;
				end else if (len_nxt == ted_pkg::SEQ_4 && (cp_nxt < ted_pkg::CP_MIN4 ||
					cp_nxt > ted_pkg::CP_MAX)) begin
					fail_nxt = 1'b1;
				end
			end
		end
	end

	// Buffer state registers, cleared after a closing item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			held_q  <= '0;
			rem_q   <= '0;
			len_q   <= ted_pkg::SEQ_NONE;
			cp_q    <= '0;
			start_q <= 1'b0;
			bad_q   <= 1'b0;
			fail_q  <= 1'b0;
			ascii_q <= 1'b1;
		end else if (clear) begin
			count_q <= '0;
			held_q  <= '0;
			rem_q   <= '0;
			len_q   <= ted_pkg::SEQ_NONE;
			cp_q    <= '0;
			start_q <= 1'b0;
			bad_q   <= 1'b0;
			fail_q  <= 1'b0;
			ascii_q <= 1'b1;
		end else begin
			count_q <= count_nxt;
			if (take && !count_q[0]) begin
				held_q <= byte_s1;
			end
			rem_q   <= rem_nxt;
			len_q   <= len_nxt;
			cp_q    <= cp_nxt;
			start_q <= start_nxt;
			bad_q   <= bad_nxt;
			fail_q  <= fail_nxt;
			ascii_q <= ascii_nxt;
		end
	end

	// Verdict from the state after this item
	assign even  = !count_nxt[0];
	assign le_ok = even ? (!le_st.failed && le_st.count >= min_ascii_q) : (min_ascii_q == '0);
	assign be_ok = even ? (!be_st.failed && be_st.count >= min_ascii_q) : (min_ascii_q == '0);

	always_comb begin
		if (le_ok) begin
			verdict = ted_pkg::ENC_UTF16LE;
		end else if (be_ok) begin
			verdict = ted_pkg::ENC_UTF16BE;
		end else if (!fail_nxt) begin
			verdict = ascii_nxt ? ted_pkg::ENC_ASCII : ted_pkg::ENC_UTF8;
		end else begin
			verdict = ted_pkg::ENC_UNKNOWN;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			enc_q <= verdict;
		end
	end

endmodule

// ===== sim/text_encoding_detector_tb.sv =====
// Self-checking testbench for text_encoding_detector: byte buffers in,
// one verdict per buffer out, checked against an in-bench model of the
// UTF-16/UTF-8 detector. Depends on ted_pkg and the RTL.
module text_encoding_detector_tb;

	localparam int EXAMINED     = ted_pkg::MAX_BYTES_DEF;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 800;
	localparam int SETTLE       = 4;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        byte_valid   = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte    = 8'd0;
	logic        last         = 1'b0;
	logic        no_byte      = 1'b0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [2:0]  encoding;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [3:0]  cfg_data     = 4'd0;

	// Model state of the detector
	logic [3:0]  min_units;
	logic [11:0] pos_count;
	logic [1:0]  seq_left;
	logic [2:0]  seq_len;
	logic [20:0] cp_acc;
	logic        seq_first;
	logic        seq_broken;
	logic        utf8_bad;
	logic        only_ascii;
	logic [7:0]  even_byte;
	logic        le_bad;
	logic        be_bad;
	logic [3:0]  le_low;
	logic [3:0]  be_low;

	logic [2:0]  encodings_due[$];
	logic [7:0]  text_bytes[$];
	logic        no_gaps     = 1'b0;
	int          errors      = 0;
	int          items_sent  = 0;
	int unsigned cycle_count = 0;

	text_encoding_detector dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.byte_valid   (byte_valid),
		.byte_stall   (byte_stall),
		.data_byte    (data_byte),
		.last         (last),
		.no_byte      (no_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.encoding     (encoding),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("text_encoding_detector_tb: done, errors");
			$finish;
		end
	end

	// Receiver back-pressure
	always @(posedge clk) begin
		result_stall <= !no_gaps && ($urandom_range(0, 99) < 16);
	end

	task automatic report_mismatch(input string what);
		$display("mismatch: %s", what);
		errors++;
	endtask

	// Compare each result transfer with the oldest verdict due
	always @(posedge clk) begin : check_results
		logic [2:0] want;
		if (arst_n && result_valid && !result_stall) begin
			if (encodings_due.size() == 0) begin
				report_mismatch($sformatf("encoding %0d with no verdict due", encoding));
			end else begin
				want = encodings_due.pop_front();
				if (encoding !== want)
					report_mismatch($sformatf("encoding %0d, expected %0d", encoding, want));
			end
		end
	end

	// ---------------- detector model ----------------

	function logic accepted_char(input logic [20:0] c);
		logic ok;
		if (c < 21'd32) begin
			ok = (c >= 21'd7 && c <= 21'd13) || c == 21'h1B;
		end else if (c <= 21'h02FA1F) begin
			ok = 1'b1;
		end else begin
			ok = (c >= 21'h0E0000 && c <= 21'h0E01EF) ||
				(c >= 21'h0F0000 && c <= ted_pkg::CP_MAX);
		end
		return ok;
	endfunction

	function logic unit_bad(input logic [15:0] u, input logic first_pair);
		return !accepted_char({5'd0, u}) || (u == ted_pkg::CP_BOM[15:0] && !first_pair);
	endfunction

	function void clear_detector();
		pos_count  = '0;
		seq_left   = '0;
		seq_len    = ted_pkg::SEQ_NONE;
		cp_acc     = '0;
		seq_first  = 1'b0;
		seq_broken = 1'b0;
		utf8_bad   = 1'b0;
		only_ascii = 1'b1;
		even_byte  = '0;
		le_bad     = 1'b0;
		be_bad     = 1'b0;
		le_low     = '0;
		be_low     = '0;
	endfunction

	// Character, overlong, surrogate and range checks at the end of a sequence
	function void close_sequence();
		if (seq_broken || !accepted_char(cp_acc) || (cp_acc == ted_pkg::CP_BOM && !seq_first))
			utf8_bad = 1'b1;
		else if (seq_len == ted_pkg::SEQ_3 &&
			(cp_acc < ted_pkg::CP_MIN3 || cp_acc[20:11] == ted_pkg::CP_SURR))
			utf8_bad = 1'b1;
		else if (seq_len == ted_pkg::SEQ_4 &&
			(cp_acc < ted_pkg::CP_MIN4 || cp_acc > ted_pkg::CP_MAX))
			utf8_bad = 1'b1;
	endfunction

	function void absorb_byte(input logic [7:0] b);
		logic [15:0] u_le;
		logic [15:0] u_be;
		logic        first_pair;
		// UTF-16 lanes work on byte pairs
		if (!pos_count[0]) begin
			even_byte = b;
		end else begin
			first_pair = (pos_count == 12'd1);
			u_le = {b, even_byte};
			u_be = {even_byte, b};
			if (unit_bad(u_le, first_pair))
				le_bad = 1'b1;
			if (unit_bad(u_be, first_pair))
				be_bad = 1'b1;
			if (u_le < 16'd127 && le_low != ted_pkg::COUNT_MAX)
				le_low++;
			if (u_be < 16'd127 && be_low != ted_pkg::COUNT_MAX)
				be_low++;
		end
		// UTF-8 decode stops at the first failure
		if (!utf8_bad) begin
			if (seq_left == 2'd0) begin
				seq_first  = (pos_count == 12'd0);
				seq_broken = 1'b0;
				if (b <= 8'h7F) begin
					seq_len = ted_pkg::SEQ_1;
					cp_acc  = {13'd0, b};
					close_sequence();
				end else begin
					only_ascii = 1'b0;
					if (b[7:5] == 3'b110) begin
						seq_len = ted_pkg::SEQ_2;
						cp_acc  = {16'd0, b[4:0]};
					end else if (b[7:4] == 4'b1110) begin
						seq_len = ted_pkg::SEQ_3;
						cp_acc  = {17'd0, b[3:0]};
					end else if (b[7:3] == 5'b11110) begin
						seq_len = ted_pkg::SEQ_4;
						cp_acc  = {18'd0, b[2:0]};
					end else begin
						utf8_bad = 1'b1;
						seq_len  = ted_pkg::SEQ_NONE;
					end
					if (!utf8_bad)
						seq_left = 2'(seq_len - 3'd1);
				end
			end else begin
				if (b[7:6] != 2'b10)
					seq_broken = 1'b1;
				cp_acc = {cp_acc[14:0], b[5:0]};
				seq_left--;
				if (seq_left == 2'd0)
					close_sequence();
			end
		end
		pos_count++;
	endfunction

	function logic [2:0] pick_verdict();
		logic le_ok;
		logic be_ok;
		if (!pos_count[0]) begin
			le_ok = !le_bad && le_low >= min_units;
			be_ok = !be_bad && be_low >= min_units;
		end else begin
			// odd length: both counts read as zero
			le_ok = (min_units == 4'd0);
			be_ok = le_ok;
		end
		if (le_ok)
			return ted_pkg::ENC_UTF16LE;
		if (be_ok)
			return ted_pkg::ENC_UTF16BE;
		if (!utf8_bad)
			return only_ascii ? ted_pkg::ENC_ASCII : ted_pkg::ENC_UTF8;
		return ted_pkg::ENC_UNKNOWN;
	endfunction

	function void predict_item(input logic [7:0] b, input logic l, input logic nb);
		if (!nb && pos_count < 12'(EXAMINED))
			absorb_byte(b);
		if (l) begin
			encodings_due.push_back(pick_verdict());
			clear_detector();
		end
	endfunction

	// ---------------- driving ----------------

	// One byte-channel transfer, with random gaps ahead of it
	task automatic send_item(input logic [7:0] b, input logic l, input logic nb);
		while (!no_gaps && $urandom_range(0, 99) < 16) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte  <= b;
		last       <= l;
		no_byte    <= nb;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		predict_item(b, l, nb);
	endtask

	task automatic wait_results();
		byte_valid <= 1'b0;
		while (encodings_due.size() != 0)
			@(posedge clk);
	endtask

	// Register write only once the block has drained
	task automatic write_min_ascii(input logic [3:0] v);
		wait_results();
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		min_units = v;
	endtask

	// Send text_bytes as one buffer; ends on the last byte or on a separate empty item
	task automatic send_text();
		int   n;
		logic end_here;
		n        = text_bytes.size();
		end_here = 1'b0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_item(8'($urandom()), 1'b0, 1'b1);
			end_here = (i == n - 1) && ($urandom_range(0, 3) != 0);
			send_item(text_bytes[i], end_here, 1'b0);
			items_sent++;
		end
		if (!end_here) begin
			send_item(8'($urandom()), 1'b1, 1'b1);
			items_sent++;
		end
	endtask

	// ---------------- text generation ----------------

	function logic [15:0] pick_unit();
		logic [15:0] u;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: u = 16'($urandom_range(16'h20, 16'h7E));
			6: u = ($urandom_range(0, 7) == 7) ? 16'h1B : 16'($urandom_range(7, 13));
			7: u = 16'($urandom_range(0, 31));
			8: u = 16'($urandom_range(127, 16'hFFFF));
			default: u = ted_pkg::CP_BOM[15:0];
		endcase
		return u;
	endfunction

	function logic [20:0] pick_cp();
		logic [20:0] c;
		case ($urandom_range(0, 11))
			0, 1, 2, 3: c = 21'($urandom_range(8'h20, 8'h7E));
			4: c = 21'($urandom_range(21'h80, 21'h7FF));
			5: c = 21'($urandom_range(21'h800, 21'hFFFF));
			6: c = 21'($urandom_range(21'h10000, 21'h10FFFF));
			7: c = ted_pkg::CP_BOM;
			8: c = 21'($urandom_range(21'hD800, 21'hDFFF));
			9: c = 21'($urandom_range(21'h2FA20, 21'hDFFFF));
			10: c = 21'($urandom_range(21'hE0000, 21'hE01EF));
			default: c = 21'($urandom_range(0, 31));
		endcase
		return c;
	endfunction

	task automatic put_unit(input logic [15:0] u, input logic big);
		if (big) begin
			text_bytes.push_back(u[15:8]);
			text_bytes.push_back(u[7:0]);
		end else begin
			text_bytes.push_back(u[7:0]);
			text_bytes.push_back(u[15:8]);
		end
	endtask

	task automatic put_cp(input logic [20:0] c, input int len);
		case (len)
			1: text_bytes.push_back({1'b0, c[6:0]});
			2: begin
				text_bytes.push_back({3'b110, c[10:6]});
				text_bytes.push_back({2'b10, c[5:0]});
			end
			3: begin
				text_bytes.push_back({4'b1110, c[15:12]});
				text_bytes.push_back({2'b10, c[11:6]});
				text_bytes.push_back({2'b10, c[5:0]});
			end
			default: begin
				text_bytes.push_back({5'b11110, c[20:18]});
				text_bytes.push_back({2'b10, c[17:12]});
				text_bytes.push_back({2'b10, c[11:6]});
				text_bytes.push_back({2'b10, c[5:0]});
			end
		endcase
	endtask

	task automatic put_utf16_text(input int n, input logic big);
		repeat (n) put_unit(pick_unit(), big);
	endtask

	// Mostly shortest-form sequences, now and then an overlong one
	task automatic put_utf8_text(input int n);
		logic [20:0] c;
		int          len;
		repeat (n) begin
			c   = pick_cp();
			len = (c < 21'h80) ? 1 : (c < 21'h800) ? 2 : (c < 21'h10000) ? 3 : 4;
			if ($urandom_range(0, 11) == 0 && len < 4)
				len++;
			put_cp(c, len);
		end
	endtask

	task automatic build_text();
		int n;
		int k;
		text_bytes.delete();
		n = ($urandom_range(0, 3) == 0) ? $urandom_range(13, 24) : $urandom_range(0, 12);
		case ($urandom_range(0, 9))
			0, 1: put_utf16_text(n, 1'b0);
			2: put_utf16_text(n, 1'b1);
			3, 4: put_utf8_text(n);
			5: repeat (2 * n) text_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
			6: begin
				// damaged UTF-8: flipped bit, cut tail or stray byte
				put_utf8_text(n + 1);
				k = $urandom_range(0, text_bytes.size() - 1);
				case ($urandom_range(0, 2))
					0: text_bytes[k] = text_bytes[k] ^ 8'(1 << $urandom_range(0, 7));
					1: text_bytes.pop_back();
					default: text_bytes.insert(k, 8'($urandom_range(8'h80, 8'hFF)));
				endcase
			end
			7: repeat (n) text_bytes.push_back(8'($urandom()));
			8: begin
				// byte order marks at the start and in the middle
				case ($urandom_range(0, 3))
					0: begin
						put_unit(ted_pkg::CP_BOM[15:0], 1'b0);
						put_utf16_text(n, 1'b0);
					end
					1: begin
						put_unit(ted_pkg::CP_BOM[15:0], 1'b1);
						put_utf16_text(n, 1'b1);
					end
					2: begin
						put_cp(ted_pkg::CP_BOM, 3);
						put_utf8_text(n);
					end
					default: begin
						put_utf16_text(n, 1'b0);
						put_unit(ted_pkg::CP_BOM[15:0], 1'b0);
						put_utf16_text(2, 1'b0);
					end
				endcase
			end
			default: begin
				put_utf16_text(n, 1'b0);
				text_bytes.push_back(8'($urandom()));
			end
		endcase
	endtask

	// ---------------- tests ----------------

	// Reset threshold: empty buffer, NUL, UTF-8 forms and the UTF-8 faults
	task automatic test_directed();
		send_item(8'hA5, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hE2, 1'b0, 1'b0);
		send_item(8'h3C, 1'b0, 1'b1);
		send_item(8'h82, 1'b0, 1'b0);
		send_item(8'hAC, 1'b1, 1'b0);
		// cut off by the end of the buffer
		send_item(8'hE2, 1'b0, 1'b0);
		send_item(8'h82, 1'b0, 1'b0);
		send_item(8'hFF, 1'b1, 1'b1);
		// bad continuation
		send_item(8'hC3, 1'b0, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		// overlong three-byte form
		send_item(8'hE0, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		// leading BOM then ASCII
		send_item(8'hEF, 1'b0, 1'b0);
		send_item(8'hBB, 1'b0, 1'b0);
		send_item(8'hBF, 1'b0, 1'b0);
		send_item(8'h41, 1'b1, 1'b0);
		// surrogate
		send_item(8'hED, 1'b0, 1'b0);
		send_item(8'hA0, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
		// above the top code point
		send_item(8'hF4, 1'b0, 1'b0);
		send_item(8'h90, 1'b0, 1'b0);
		send_item(8'h80, 1'b0, 1'b0);
		send_item(8'h80, 1'b1, 1'b0);
	endtask

	// Zero threshold: odd lengths and empty buffers qualify as UTF-16
	task automatic test_min_zero();
		write_min_ascii(4'd0);
		send_item(8'h41, 1'b1, 1'b0);
		send_item(8'h01, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h5A, 1'b1, 1'b1);
		send_item(8'h00, 1'b0, 1'b0);
		send_item(8'h00, 1'b1, 1'b0);
	endtask

	// Top threshold: counts must saturate, not wrap, to stay at it
	task automatic test_min_max();
		write_min_ascii(4'd15);
		text_bytes.delete();
		repeat (16) put_unit(16'h0061, 1'b0);
		send_text();
		text_bytes.delete();
		repeat (16) put_unit(16'h0061, 1'b1);
		send_text();
	endtask

	task automatic test_random();
		logic [3:0] setting;
		int         budget;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0: setting = ted_pkg::MIN_ASCII_RST;
				1: setting = 4'd0;
				2: setting = 4'd15;
				3: setting = 4'($urandom_range(1, 14));
				default: setting = 4'($urandom_range(0, 15));
			endcase
			write_min_ascii(setting);
			no_gaps = (p == 3);
			budget  = items_sent + RANDOM_ITEMS / 5;
			while (items_sent < budget) begin
				build_text();
				send_text();
				if ($urandom_range(0, 9) == 0)
					wait_results();
			end
			no_gaps = 1'b0;
		end
	endtask

	initial begin
		min_units = ted_pkg::MIN_ASCII_RST;
		clear_detector();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_min_zero();
		test_min_max();
		test_random();

		wait_results();
		repeat (8) @(posedge clk);
		if (errors == 0 && encodings_due.size() == 0) begin
			$display("text_encoding_detector_tb: done, clean");
		end else begin
			$display("text_encoding_detector_tb: done, errors");
		end
		$finish;
	end

endmodule
